// ----- src/dtwp_pkg.sv -----
// ============================================================================
// Waypoint drive controller package
// Types, register map and constants shared by the controller, the datapath,
// the register file and the top level.
// ============================================================================
package dtwp_pkg;

   // Encoder tick length in Q16 inches, as a signed multiplier operand.
   localparam logic signed [17:0] INCH_PER_TICK_Q16 = 18'sd2287;

   // Register file geometry.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_TARGET_DISTANCE = 3'd0;
   localparam logic [2:0] REG_TARGET_TURN     = 3'd1;
   localparam logic [2:0] REG_TRAVEL_GAIN     = 3'd2;
   localparam logic [2:0] REG_TURN_GAIN       = 3'd3;
   localparam logic [2:0] REG_TOP_SPEED       = 3'd4;
   localparam logic [2:0] REG_FLOOR_SPEED     = 3'd5;
   localparam logic [2:0] REG_SLOW_ZONE       = 3'd6;
   localparam logic [2:0] REG_RAMP_TIME       = 3'd7;

   // Register reset values.
   localparam logic [23:0] RST_TARGET_DISTANCE = 24'd0;
   localparam logic [12:0] RST_TARGET_TURN     = 13'd0;
   localparam logic [15:0] RST_TRAVEL_GAIN     = 16'd512;
   localparam logic [15:0] RST_TURN_GAIN       = 16'd25600;
   localparam logic [6:0]  RST_TOP_SPEED       = 7'd100;
   localparam logic [6:0]  RST_FLOOR_SPEED     = 7'd15;
   localparam logic [15:0] RST_SLOW_ZONE       = 16'd4608;
   localparam logic [15:0] RST_RAMP_TIME       = 16'd500;

   // Speed phase codes.
   localparam logic [1:0] PHASE_AT_DIST = 2'd0;
   localparam logic [1:0] PHASE_SLOWING = 2'd1;
   localparam logic [1:0] PHASE_ACCEL   = 2'd2;
   localparam logic [1:0] PHASE_COAST   = 2'd3;

   // Tolerances and the fixed balance nudge.
   localparam logic [36:0]        NEAR_Q8   = 37'd128;
   localparam logic signed [17:0] TURN_TOL  = 18'sd2;
   localparam logic signed [25:0] BAL_TOL   = 26'sd5;
   localparam logic signed [28:0] BAL_NUDGE = 29'sd50;

   // Ramp divider: quotient is below top speed, so seven bits.
   localparam int unsigned DIV_STEPS = 7;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Configuration register contents.
   typedef struct packed {
      logic signed [23:0] target_distance;
      logic signed [12:0] target_turn;
      logic [15:0]        travel_gain;
      logic [15:0]        turn_gain;
      logic [6:0]         top_speed;
      logic [6:0]         floor_speed;
      logic [15:0]        slow_zone;
      logic [15:0]        ramp_time;
   } cfg_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_DIST,
      ST_ERR,
      ST_MUL_MAG,
      ST_MUL_ROT,
      ST_MUL_RAMP,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Operand selection for the shared multiplier.
   typedef enum logic [1:0] {
      MUL_DIST,
      MUL_MAG,
      MUL_ROT,
      MUL_RAMP
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_in;
      logic        diff_en;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        err_en;
      logic        magp_en;
      logic        rotp_en;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } cmd_type;

endpackage

// ----- src/drive_to_waypoint_p_controller.sv -----
// ============================================================================
// Waypoint drive controller
// Proportional distance control with an acceleration ramp and proportional
// heading control, one command word per input word.
// ============================================================================
// Each accepted word yields one result word, registered in the output
// register once that register is free, and the next word is taken the cycle
// after the result is registered, so the block works on one word at a time.
// Its pace is set by the sequencer: a single shared signed multiplier is used four
// times in turn (distance, speed gain, turn gain, ramp numerator) and the ramp
// quotient comes from a seven-step restoring divider. The result sits in an
// output register, so a new word is accepted while the previous result waits
// to be taken. The configuration registers sit at byte addresses 0 to 28, one
// every four bytes, and must be written only while the block is idle.
module drive_to_waypoint_p_controller (
   input  logic                            clock,
   input  logic                            reset,
   // Input words.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_start_step,
   input  logic signed [23:0]              req_left_count,
   input  logic signed [23:0]              req_right_count,
   input  logic signed [15:0]              req_heading,
   input  logic [15:0]                     req_elapsed_ms,
   // Result words.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [7:0]               rsp_drive_cmd,
   output logic signed [7:0]               rsp_turn_cmd,
   output logic [1:0]                      rsp_phase,
   output logic                            rsp_at_distance,
   output logic                            rsp_finished,
   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dtwp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dtwp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dtwp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   dtwp_pkg::cfg_type cfg;
   dtwp_pkg::cmd_type cmd;

   // Configuration registers.
   dtwp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer.
   dtwp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath.
   dtwp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_start_step  (req_start_step),
      .req_left_count  (req_left_count),
      .req_right_count (req_right_count),
      .req_heading     (req_heading),
      .req_elapsed_ms  (req_elapsed_ms),
      .rsp_drive_cmd   (rsp_drive_cmd),
      .rsp_turn_cmd    (rsp_turn_cmd),
      .rsp_phase       (rsp_phase),
      .rsp_at_distance (rsp_at_distance),
      .rsp_finished    (rsp_finished)
   );

`ifndef NO_ASSERTIONS
   // The block works on one word at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a word is in progress");

   // A finished result carries zero commands.
   a_finished_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_drive_cmd == 8'sd0 && rsp_turn_cmd == 8'sd0))
      else $error("finished result with a nonzero command");

   // Finishing requires the distance flag.
   a_finished_reached: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> rsp_at_distance)
      else $error("finished without distance reached");

   // The at-distance phase always sets the sticky flag.
   a_phase_reached: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase == dtwp_pkg::PHASE_AT_DIST) |-> rsp_at_distance)
      else $error("at-distance phase without the distance flag");
`endif

endmodule

// ----- src/dtwp_csr.sv -----
// ============================================================================
// Waypoint drive controller register file
// APB-style configuration registers with reset values and a read mux.
// ============================================================================
module dtwp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dtwp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dtwp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dtwp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output dtwp_pkg::cfg_type                  cfg
);

   dtwp_pkg::cfg_type cfg_ff;
   dtwp_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Next register contents on a completed write.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            dtwp_pkg::REG_TARGET_DISTANCE: cfg_in.target_distance = csr_pwdata[23:0];
            dtwp_pkg::REG_TARGET_TURN:     cfg_in.target_turn     = csr_pwdata[12:0];
            dtwp_pkg::REG_TRAVEL_GAIN:     cfg_in.travel_gain     = csr_pwdata[15:0];
            dtwp_pkg::REG_TURN_GAIN:       cfg_in.turn_gain       = csr_pwdata[15:0];
            dtwp_pkg::REG_TOP_SPEED:       cfg_in.top_speed       = csr_pwdata[6:0];
            dtwp_pkg::REG_FLOOR_SPEED:     cfg_in.floor_speed     = csr_pwdata[6:0];
            dtwp_pkg::REG_SLOW_ZONE:       cfg_in.slow_zone       = csr_pwdata[15:0];
            dtwp_pkg::REG_RAMP_TIME:       cfg_in.ramp_time       = csr_pwdata[15:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_distance <= dtwp_pkg::RST_TARGET_DISTANCE;
         cfg_ff.target_turn     <= dtwp_pkg::RST_TARGET_TURN;
         cfg_ff.travel_gain     <= dtwp_pkg::RST_TRAVEL_GAIN;
         cfg_ff.turn_gain       <= dtwp_pkg::RST_TURN_GAIN;
         cfg_ff.top_speed       <= dtwp_pkg::RST_TOP_SPEED;
         cfg_ff.floor_speed     <= dtwp_pkg::RST_FLOOR_SPEED;
         cfg_ff.slow_zone       <= dtwp_pkg::RST_SLOW_ZONE;
         cfg_ff.ramp_time       <= dtwp_pkg::RST_RAMP_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux; values are returned zero-extended.
   always_comb begin
      case (index)
         dtwp_pkg::REG_TARGET_DISTANCE: csr_prdata = {8'd0, cfg_ff.target_distance};
         dtwp_pkg::REG_TARGET_TURN:     csr_prdata = {19'd0, cfg_ff.target_turn};
         dtwp_pkg::REG_TRAVEL_GAIN:     csr_prdata = {16'd0, cfg_ff.travel_gain};
         dtwp_pkg::REG_TURN_GAIN:       csr_prdata = {16'd0, cfg_ff.turn_gain};
         dtwp_pkg::REG_TOP_SPEED:       csr_prdata = {25'd0, cfg_ff.top_speed};
         dtwp_pkg::REG_FLOOR_SPEED:     csr_prdata = {25'd0, cfg_ff.floor_speed};
         dtwp_pkg::REG_SLOW_ZONE:       csr_prdata = {16'd0, cfg_ff.slow_zone};
         dtwp_pkg::REG_RAMP_TIME:       csr_prdata = {16'd0, cfg_ff.ramp_time};
         default:                       csr_prdata = '0;
      endcase
   end

endmodule

// ----- src/dtwp_ctrl.sv -----
// ============================================================================
// Waypoint drive controller sequencer
// Steps one word through the datapath: differences, four uses of the shared
// multiplier, the ramp divider and the final selection into the output word.
// ============================================================================
module dtwp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtwp_pkg::cmd_type cmd
);

   dtwp_pkg::state_type                state_ff;
   dtwp_pkg::state_type                state_in;
   logic [dtwp_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [dtwp_pkg::DIV_CNT_W-1:0]     cnt_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               out_free;
   logic                               div_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_last  = (cnt_ff == dtwp_pkg::DIV_CNT_W'(dtwp_pkg::DIV_STEPS - 1));
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtwp_pkg::ST_IDLE:     if (req_valid) state_in = dtwp_pkg::ST_DIFF;
         dtwp_pkg::ST_DIFF:     state_in = dtwp_pkg::ST_MUL_DIST;
         dtwp_pkg::ST_MUL_DIST: state_in = dtwp_pkg::ST_ERR;
         dtwp_pkg::ST_ERR:      state_in = dtwp_pkg::ST_MUL_MAG;
         dtwp_pkg::ST_MUL_MAG:  state_in = dtwp_pkg::ST_MUL_ROT;
         dtwp_pkg::ST_MUL_ROT:  state_in = dtwp_pkg::ST_MUL_RAMP;
         dtwp_pkg::ST_MUL_RAMP: state_in = dtwp_pkg::ST_DIV_LOAD;
         dtwp_pkg::ST_DIV_LOAD: state_in = dtwp_pkg::ST_DIV;
         dtwp_pkg::ST_DIV:      if (div_last) state_in = dtwp_pkg::ST_FINISH;
         dtwp_pkg::ST_FINISH:   if (out_free) state_in = dtwp_pkg::ST_IDLE;
         default:               state_in = dtwp_pkg::ST_IDLE;
      endcase
   end

   // Commands per state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         dtwp_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         dtwp_pkg::ST_DIFF: cmd.diff_en = 1'b1;
         dtwp_pkg::ST_MUL_DIST: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dtwp_pkg::MUL_DIST;
         end
         dtwp_pkg::ST_ERR: cmd.err_en = 1'b1;
         dtwp_pkg::ST_MUL_MAG: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dtwp_pkg::MUL_MAG;
         end
         dtwp_pkg::ST_MUL_ROT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dtwp_pkg::MUL_ROT;
            cmd.magp_en = 1'b1;
         end
         dtwp_pkg::ST_MUL_RAMP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dtwp_pkg::MUL_RAMP;
            cmd.rotp_en = 1'b1;
         end
         dtwp_pkg::ST_DIV_LOAD: cmd.div_init = 1'b1;
         dtwp_pkg::ST_DIV:      cmd.div_step = 1'b1;
         dtwp_pkg::ST_FINISH:   cmd.out_load = out_free;
         default:               cmd = '0;
      endcase
   end

   // Divider step counter and output word valid.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.div_init) begin
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtwp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/dtwp_dp.sv -----
// ============================================================================
// Waypoint drive controller datapath
// Baselines, encoder and heading differences, a shared signed multiplier,
// a restoring ramp divider and the phase and command selection.
// ============================================================================
module dtwp_dp (
   input  logic               clock,
   input  logic               reset,
   input  dtwp_pkg::cmd_type  cmd,
   input  dtwp_pkg::cfg_type  cfg,
   input  logic               req_start_step,
   input  logic signed [23:0] req_left_count,
   input  logic signed [23:0] req_right_count,
   input  logic signed [15:0] req_heading,
   input  logic [15:0]        req_elapsed_ms,
   output logic signed [7:0]  rsp_drive_cmd,
   output logic signed [7:0]  rsp_turn_cmd,
   output logic [1:0]         rsp_phase,
   output logic               rsp_at_distance,
   output logic               rsp_finished
);

   // Latched input word and step state.
   logic signed [23:0] left_ff, right_ff;
   logic signed [15:0] heading_ff;
   logic [15:0]        elapsed_ff;
   logic [23:0]        base_left_ff, base_right_ff;
   logic [15:0]        base_heading_ff;
   logic               reached_ff;
   logic               reached_in;

   // Intermediate results.
   logic signed [24:0] dl, dr;
   logic signed [25:0] sum_in, sum_ff, bal_in, bal_ff;
   logic signed [17:0] aerr_in, aerr_ff;
   logic signed [26:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [44:0] prod_in, prod_ff;
   logic signed [44:0] prod_b9, prod_b16, prod_b8;
   logic signed [35:0] travel_q8;
   logic signed [36:0] err_in, err_ff;
   logic [36:0]        abserr_in, abserr_ff;
   logic signed [17:0] magp_ff;
   logic signed [27:0] rotp_ff;
   logic [22:0]        rem_ff, rem_in;
   logic [21:0]        dsr_ff, dsr_in;
   logic [6:0]         quo_ff, quo_in;

   // Final selection.
   logic               near, slow, ramp, forward, straight, good_rot, fin, now_reached;
   logic signed [19:0] top20, flr20, mag, mag_v;
   logic signed [28:0] top29, flr29, rot, rot_v;
   logic [1:0]         phase;

   logic signed [7:0]  drive_ff, turn_ff;
   logic [1:0]         phase_ff;
   logic               at_dist_ff, fin_ff;

   // Input latch and baselines on a new step; the baselines clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_left_ff    <= '0;
         base_right_ff   <= '0;
         base_heading_ff <= '0;
      end else if (cmd.load_in) begin
         left_ff    <= req_left_count;
         right_ff   <= req_right_count;
         heading_ff <= req_heading;
         elapsed_ff <= req_elapsed_ms;
         if (req_start_step) begin
            base_left_ff    <= req_left_count;
            base_right_ff   <= req_right_count;
            base_heading_ff <= req_heading;
         end
      end
   end

   // Sticky distance flag: cleared on a new step, set when a word is near.
   always_comb begin
      reached_in = reached_ff;
      if (cmd.load_in && req_start_step) begin
         reached_in = 1'b0;
      end else if (cmd.out_load && near) begin
         reached_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff <= 1'b0;
      end else begin
         reached_ff <= reached_in;
      end
   end

   // Encoder and heading differences.
   always_comb begin
      dl      = $signed({left_ff[23], left_ff}) - $signed({base_left_ff[23], base_left_ff});
      dr      = $signed({right_ff[23], right_ff})
                - $signed({base_right_ff[23], base_right_ff});
      sum_in  = $signed({dl[24], dl}) + $signed({dr[24], dr});
      bal_in  = $signed({dr[24], dr}) - $signed({dl[24], dl});
      aerr_in = $signed({{5{cfg.target_turn[12]}}, cfg.target_turn})
                - ($signed({{2{base_heading_ff[15]}}, base_heading_ff})
                   - $signed({{2{heading_ff[15]}}, heading_ff}));
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         sum_ff  <= sum_in;
         bal_ff  <= bal_in;
         aerr_ff <= aerr_in;
      end
   end

   // Shared multiplier with operand selection.
   always_comb begin
      case (cmd.mul_sel)
         dtwp_pkg::MUL_DIST: begin
            mul_a = $signed({sum_ff[25], sum_ff});
            mul_b = dtwp_pkg::INCH_PER_TICK_Q16;
         end
         dtwp_pkg::MUL_MAG: begin
            mul_a = $signed({{9{err_ff[17]}}, err_ff[17:0]});
            mul_b = $signed({2'b00, cfg.travel_gain});
         end
         dtwp_pkg::MUL_ROT: begin
            mul_a = $signed({{9{aerr_ff[17]}}, aerr_ff});
            mul_b = $signed({2'b00, cfg.turn_gain});
         end
         dtwp_pkg::MUL_RAMP: begin
            mul_a = $signed({11'd0, elapsed_ff});
            mul_b = $signed({11'd0, cfg.top_speed});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Shifts that round toward zero: bias negative products before the shift.
   always_comb begin
      prod_b9   = prod_ff + (prod_ff[44] ? 45'sd511 : 45'sd0);
      prod_b16  = prod_ff + (prod_ff[44] ? 45'sd65535 : 45'sd0);
      prod_b8   = prod_ff + (prod_ff[44] ? 45'sd255 : 45'sd0);
      travel_q8 = prod_b9[44:9];
      err_in    = $signed({{13{cfg.target_distance[23]}}, cfg.target_distance})
                  - $signed({travel_q8[35], travel_q8});
      abserr_in = err_in[36] ? 37'(-err_in) : 37'(err_in);
   end

   // Distance error and the two proportional terms.
   always_ff @(posedge clock) begin
      if (cmd.err_en) begin
         err_ff    <= err_in;
         abserr_ff <= abserr_in;
      end
      if (cmd.magp_en) begin
         magp_ff <= prod_b16[33:16];
      end
      if (cmd.rotp_en) begin
         rotp_ff <= prod_b8[35:8];
      end
   end

   // Restoring divider for the ramp: one quotient bit per step.
   always_comb begin
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = prod_ff[22:0];
         dsr_in = {cfg.ramp_time, 6'd0};
         quo_in = '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= {1'b0, dsr_ff}) begin
            rem_in = rem_ff - {1'b0, dsr_ff};
            quo_in = {quo_ff[5:0], 1'b1};
         end else begin
            quo_in = {quo_ff[5:0], 1'b0};
         end
         dsr_in = {1'b0, dsr_ff[21:1]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   // Speed magnitude and phase.
   always_comb begin
      near     = abserr_ff < dtwp_pkg::NEAR_Q8;
      slow     = abserr_ff < {21'd0, cfg.slow_zone};
      ramp     = elapsed_ff < cfg.ramp_time;
      forward  = !cfg.target_distance[23];
      straight = (cfg.target_turn == 13'd0);
      top20    = $signed({13'd0, cfg.top_speed});
      flr20    = $signed({13'd0, cfg.floor_speed});
      mag_v    = '0;
      if (near) begin
         mag   = '0;
         phase = dtwp_pkg::PHASE_AT_DIST;
      end else if (slow) begin
         phase = dtwp_pkg::PHASE_SLOWING;
         if (forward) begin
            mag_v = $signed({{2{magp_ff[17]}}, magp_ff}) + flr20;
            if (mag_v > top20) begin
               mag = top20;
            end else if (mag_v < flr20) begin
               mag = flr20;
            end else begin
               mag = mag_v;
            end
         end else begin
            mag_v = $signed({{2{magp_ff[17]}}, magp_ff}) - flr20;
            if (mag_v > -flr20) begin
               mag = -flr20;
            end else if (mag_v < -top20) begin
               mag = -top20;
            end else begin
               mag = mag_v;
            end
         end
      end else if (ramp) begin
         phase = dtwp_pkg::PHASE_ACCEL;
         mag   = forward ? $signed({13'd0, quo_ff}) : -$signed({13'd0, quo_ff});
      end else begin
         phase = dtwp_pkg::PHASE_COAST;
         mag   = forward ? top20 : -top20;
      end
   end

   // Rotation command, balance nudge and the finished override.
   always_comb begin
      now_reached = reached_ff || near;
      top29       = $signed({22'd0, cfg.top_speed});
      flr29       = $signed({22'd0, cfg.floor_speed});
      good_rot    = 1'b0;
      rot         = '0;
      rot_v       = '0;
      if (!straight) begin
         if ((aerr_ff > -dtwp_pkg::TURN_TOL) && (aerr_ff < dtwp_pkg::TURN_TOL)) begin
            good_rot = 1'b1;
         end else if (!aerr_ff[17]) begin
            rot_v = $signed({rotp_ff[27], rotp_ff}) + flr29;
            if (rot_v > top29) begin
               rot = top29;
            end else if (rot_v < -top29) begin
               rot = -top29;
            end else begin
               rot = rot_v;
            end
         end else begin
            rot_v = $signed({rotp_ff[27], rotp_ff}) - flr29;
            if (rot_v > -flr29) begin
               rot = -flr29;
            end else if (rot_v < -top29) begin
               rot = -top29;
            end else begin
               rot = rot_v;
            end
         end
      end else if (now_reached) begin
         if ((bal_ff > -dtwp_pkg::BAL_TOL) && (bal_ff < dtwp_pkg::BAL_TOL)) begin
            good_rot = 1'b1;
         end else if (bal_ff > 26'sd0) begin
            rot = dtwp_pkg::BAL_NUDGE;
         end else begin
            rot = -dtwp_pkg::BAL_NUDGE;
         end
      end
      fin = now_reached && good_rot;
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         drive_ff   <= (fin || (straight && now_reached)) ? 8'sd0 : mag[7:0];
         turn_ff    <= fin ? 8'sd0 : rot[7:0];
         phase_ff   <= phase;
         at_dist_ff <= now_reached;
         fin_ff     <= fin;
      end
   end

   assign rsp_drive_cmd   = drive_ff;
   assign rsp_turn_cmd    = turn_ff;
   assign rsp_phase       = phase_ff;
   assign rsp_at_distance = at_dist_ff;
   assign rsp_finished    = fin_ff;

endmodule
